### src/aesctr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesctr_pkg
// shared types, constants and aes helper functions for the ctr byte cipher
// ----------------------------------------------------------------------------
package aesctr_pkg;

    localparam int BLOCK_BYTES   = 16;
    localparam int COUNTER_BYTES = 8;

    typedef enum logic [1:0] {
        KEY_MODE_NONE = 2'd0,
        KEY_MODE_128  = 2'd1,
        KEY_MODE_192  = 2'd2,
        KEY_MODE_256  = 2'd3
    } t_key_mode;

    typedef enum logic [2:0] {
        REG_KEY_MODE = 3'd0,
        REG_KEY_W0   = 3'd1,
        REG_KEY_W1   = 3'd2,
        REG_KEY_W2   = 3'd3,
        REG_KEY_W3   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXPAND,
        ST_ROUND,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_in;   // capture input beat
        logic restart;   // clear counter and position
        logic load;      // bump counter, seed key schedule and state
        logic kstep;     // one key schedule word step
        logic rstep;     // one aes round
        logic emit;      // form output byte
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_refill;
        logic kword_ready;   // four new schedule words available
        logic last_round;
    } t_sts;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of the aes state sits in bits 8*i+7 : 8*i
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
        logic [127:0] t;
        logic [127:0] m;
        logic [7:0]   a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r + 4*((c+r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[8*(4*c)   +: 8];
            a1 = t[8*(4*c+1) +: 8];
            a2 = t[8*(4*c+2) +: 8];
            a3 = t[8*(4*c+3) +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            m[8*(4*c)   +: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            m[8*(4*c+1) +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            m[8*(4*c+2) +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            m[8*(4*c+3) +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        aes_round = mix ? m : t;
    endfunction

endpackage
`default_nettype wire

### src/aesctr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesctr_ctrl
// sequencer: accepts a beat, runs key schedule and rounds on refill, emits
// ----------------------------------------------------------------------------
module aesctr_ctrl
    import aesctr_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    input  wire  i_in_start,
    input  wire  i_out_busy,     // output register full and not drained
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_start || i_sts.need_refill) ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD:   n_state = ST_EXPAND;
            ST_EXPAND: if (i_sts.kword_ready) n_state = ST_ROUND;
            ST_ROUND: begin
                if (i_sts.last_round) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_EXPAND;
                end
            end
            ST_OUT:    if (!i_out_busy) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.take_in   = i_in_valid;
                o_cmd.restart   = i_in_valid && i_in_start;
            end
            ST_LOAD:   o_cmd.load  = 1'b1;
            ST_EXPAND: o_cmd.kstep = !i_sts.kword_ready;
            ST_ROUND:  o_cmd.rstep = 1'b1;
            ST_OUT:    o_cmd.emit  = !i_out_busy;
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_EXPAND)
        else $error("load not followed by expansion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == ST_IDLE)
        else $error("ready outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_state == ST_IDLE)
        else $error("emit did not return to idle");

endmodule
`default_nettype wire

### src/aesctr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aesctr_dp
// counter, keystream block, on-the-fly key schedule and iterative round unit
// ----------------------------------------------------------------------------
module aesctr_dp
    import aesctr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [63:0] i_cfg_data,
    input  wire  [7:0]  i_data,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [7:0]  o_byte
);

    logic [1:0]   r_key_mode;
    logic [63:0]  r_key [4];
    logic [63:0]  r_ctr;
    logic [127:0] r_ks;
    logic [4:0]   r_pos;
    logic [7:0]   r_data;
    // key schedule sliding window of the last nk words (up to eight)
    logic [31:0]  r_kw [8];
    logic [3:0]   r_nk;
    logic [2:0]   r_kmod;     // index of next schedule word modulo nk
    logic [2:0]   r_kcnt;     // words generated for the current round
    logic [3:0]   r_round;
    logic [3:0]   r_nr;
    logic [7:0]   r_rcon;
    logic [127:0] r_st;

    // schedule word generation
    logic [31:0]  w_prev, w_t, w_new;
    logic [2:0]   w_mod;
    logic [127:0] w_rk;
    logic [127:0] w_rnd;
    logic [3:0]   w_nk_cfg;

    always_comb begin
        case (t_key_mode'(r_key_mode))
            KEY_MODE_192: w_nk_cfg = 4'd6;
            KEY_MODE_256: w_nk_cfg = 4'd8;
            default:      w_nk_cfg = 4'd4;
        endcase
    end

    always_comb begin
        w_prev = r_kw[r_nk[2:0] - 3'd1];
        w_mod  = r_kmod;
        w_t    = w_prev;
        if (w_mod == 3'd0) begin
            w_t = {SBOX[w_prev[7:0]], SBOX[w_prev[31:24]], SBOX[w_prev[23:16]],
                   SBOX[w_prev[15:8]] ^ r_rcon};
        end else if (r_nk == 4'd8 && w_mod == 3'd4) begin
            w_t = {SBOX[w_prev[31:24]], SBOX[w_prev[23:16]],
                   SBOX[w_prev[15:8]], SBOX[w_prev[7:0]]};
        end
        w_new = r_kw[0] ^ w_t;
        // after 4r steps the oldest four words of the window are round key r
        w_rk  = {r_kw[3], r_kw[2], r_kw[1], r_kw[0]};
        w_rnd = aes_round(r_st, !o_sts.last_round) ^ w_rk;
    end

    assign o_sts.need_refill = r_pos[4];
    assign o_sts.kword_ready = (r_kcnt == 3'd4);
    assign o_sts.last_round  = (r_round + 4'd1 == r_nr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_mode <= KEY_MODE_256;
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_ctr <= '0;
            r_pos <= 5'd16;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_KEY_MODE: r_key_mode <= i_cfg_data[1:0];
                    REG_KEY_W0:   r_key[0]   <= i_cfg_data;
                    REG_KEY_W1:   r_key[1]   <= i_cfg_data;
                    REG_KEY_W2:   r_key[2]   <= i_cfg_data;
                    REG_KEY_W3:   r_key[3]   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_ctr <= '0;
                r_pos <= 5'd16;
            end
            if (i_cmd.load) begin
                r_ctr <= r_ctr + 64'd1;
            end
            if (i_cmd.rstep && o_sts.last_round) begin
                r_pos <= 5'd0;
            end
            if (i_cmd.emit) begin
                r_pos <= r_pos + 5'd1;
            end
        end
    end

    // payload and schedule registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) r_data <= i_data;
        if (i_cmd.load) begin
            for (int i = 0; i < 8; i++) begin
                r_kw[i] <= r_key[i/2][32*(i%2) +: 32];
            end
            r_nk    <= w_nk_cfg;
            r_nr    <= w_nk_cfg + 4'd6;
            r_kmod  <= 3'd0;
            r_kcnt  <= 3'd0;
            r_round <= 4'd0;
            r_rcon  <= 8'h01;
            r_st    <= {64'd0, r_ctr + 64'd1} ^ {r_key[1], r_key[0]};
        end
        if (i_cmd.kstep) begin
            for (int i = 0; i < 8; i++) begin
                r_kw[i] <= (3'(i) == r_nk[2:0] - 3'd1) ? w_new : r_kw[(i + 1) & 7];
            end
            r_kmod <= (r_kmod == r_nk[2:0] - 3'd1) ? 3'd0 : r_kmod + 3'd1;
            r_kcnt <= r_kcnt + 3'd1;
            if (w_mod == 3'd0) r_rcon <= xtime(r_rcon);
        end
        if (i_cmd.rstep) begin
            r_st    <= w_rnd;
            r_round <= r_round + 4'd1;
            r_kcnt  <= 3'd0;
            if (o_sts.last_round) r_ks <= w_rnd;
        end
    end

    assign o_byte = r_data ^ r_ks[8*r_pos[3:0] +: 8];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_round == 4'd0)
        else $error("round count not cleared");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !r_pos[4])
        else $error("emit with empty keystream");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.restart |=> r_ctr == 64'd0)
        else $error("counter not cleared on restart");

endmodule
`default_nettype wire

### src/aes_ctr_byte_stream_cipher_core.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: each beat passes through the idle and output states while the keystream
//   holds bytes; a refill adds a load step plus, per round, four key schedule
//   steps, a handoff step and a round step
// throughput: one beat at a time, set by the shared round unit and
//   the word-serial key schedule; a stalled output holds the next beat back
// reset: synchronous active low; counter zero, keystream empty, key mode 256
// ----------------------------------------------------------------------------
// aes_ctr_byte_stream_cipher_core
// byte stream aes counter mode cipher with 64-bit little-endian counter
// ----------------------------------------------------------------------------
module aes_ctr_byte_stream_cipher_core
    import aesctr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [63:0] i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tuser,   // [0] start_message
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [7:0] out_byte
);

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [7:0] w_byte;
    logic       r_oval;
    logic [7:0] r_obyte;

    aesctr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_start (s_axis_tuser),
        .i_out_busy (r_oval && !m_axis_tready),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    aesctr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_data     (s_axis_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_byte     (w_byte)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (w_cmd.emit) begin
            r_oval <= 1'b1;
        end else if (m_axis_tready) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.emit) r_obyte <= w_byte;
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_obyte;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> !(r_oval && !m_axis_tready))
        else $error("output overwritten while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> m_axis_tvalid)
        else $error("emitted beat not presented");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |-> !w_cmd.emit)
        else $error("accept and emit in one cycle");

endmodule
`default_nettype wire
